// ----- sv/ucrc_pkg.sv -----
`timescale 1ns / 1ps

package ucrc_pkg;

   localparam int unsigned ShiftsPerCover = 12;
   localparam int unsigned NumBlocks      = 275;
   localparam int unsigned HopDivisor     = 2;

   localparam logic KIND_STORE   = 1'b0;
   localparam logic KIND_COMPARE = 1'b1;

   localparam logic [2:0] FMT_0 = 3'd0;
   localparam logic [2:0] FMT_1 = 3'd1;
   localparam logic [2:0] FMT_4 = 3'd4;

   typedef struct packed {
      logic       kind;
      logic [2:0] format;
      logic [3:0] sym_start;
      logic [3:0] sym_len;
      logic [8:0] prb_start;
      logic [4:0] prb_len;
      logic       hop_enable;
      logic [8:0] hop_prb_start;
      logic [3:0] cyclic_shift;
      logic [2:0] time_occ;
      logic [1:0] cover_index;
   } req_type;

   typedef struct packed {
      logic collide;
   } rsp_type;

endpackage

// ----- sv/ucrc_if.sv -----
`timescale 1ns / 1ps

interface ucrc_req_if;
   logic             valid;
   logic             ready;
   ucrc_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ucrc_rsp_if;
   logic             valid;
   logic             ready;
   ucrc_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/uplink_control_resource_collision.sv -----
// Path: a compare beat passes through the input register and then the result register;
// a store beat gives no result and takes effect before any later compare.
// Throughput: one beat per cycle while results are taken, set by the input and result
// registers; a stalled result holds one beat while the input register still fills.
// Reset (synchronous, active high): empties both registers and clears the kept resource.
`timescale 1ns / 1ps

module uplink_control_resource_collision (
   input  logic              clock,
   input  logic              reset,
   ucrc_req_if.sink          req_chan,
   ucrc_rsp_if.source        rsp_chan
);

   typedef struct packed {
      logic [2:0] format;
      logic [3:0] sym_start;
      logic [3:0] sym_len;
      logic [8:0] prb_start;
      logic [4:0] prb_len;
      logic       hop_enable;
      logic [8:0] hop_prb_start;
      logic [8:0] mux;
   } res_type;

   typedef struct packed {
      logic [4:0] s0;
      logic [4:0] s1;
      logic [9:0] p0;
      logic [9:0] p1;
   } rect_type;

   function automatic logic [8:0] mux_index(input logic [2:0] fmt, input logic [3:0] cs,
                                            input logic [2:0] tocc, input logic [1:0] occ);
      logic [8:0] idx;
      case (fmt)
         ucrc_pkg::FMT_0: idx = 9'(cs);
         ucrc_pkg::FMT_1: idx = 9'(cs) + 9'(tocc) * 9'(ucrc_pkg::ShiftsPerCover);
         ucrc_pkg::FMT_4: idx = 9'(occ);
         default: idx = '0;
      endcase
      return idx;
   endfunction

   function automatic rect_type hop_rect(input res_type r, input logic second);
      rect_type   h;
      logic [4:0] half;
      logic [4:0] stop;
      half = 5'(r.sym_len / ucrc_pkg::HopDivisor);
      stop = 5'(r.sym_start) + 5'(r.sym_len);
      h.p1 = 10'(r.prb_start) + 10'(r.prb_len);
      h.p0 = 10'(r.prb_start);
      if (!r.hop_enable) begin
         h.s0 = 5'(r.sym_start);
         h.s1 = stop;
      end else if (!second) begin
         h.s0 = 5'(r.sym_start);
         h.s1 = 5'(r.sym_start) + half;
      end else begin
         h.s0 = 5'(r.sym_start) + half;
         h.s1 = stop;
         h.p0 = 10'(r.hop_prb_start);
         h.p1 = 10'(r.hop_prb_start) + 10'(r.prb_len);
      end
      return h;
   endfunction

   function automatic logic rect_overlap(input rect_type a, input rect_type b);
      return (a.s0 < b.s1) && (b.s0 < a.s1) && (a.p0 < b.p1) && (b.p0 < a.p1);
   endfunction

   logic              s1_valid_ff, s1_valid_in;
   ucrc_pkg::req_type s1_data_ff;
   res_type           kept_ff;
   logic              out_valid_ff, out_valid_in;
   logic              collide_ff;
   logic              s1_advance;
   res_type           cur;
   rect_type          ha [2];
   rect_type          hb [2];
   logic              any_overlap;
   logic              hops_same;
   logic              collide_in;

   always_comb begin
      cur.format        = s1_data_ff.format;
      cur.sym_start     = s1_data_ff.sym_start;
      cur.sym_len       = s1_data_ff.sym_len;
      cur.prb_start     = s1_data_ff.prb_start;
      cur.prb_len       = s1_data_ff.prb_len;
      cur.hop_enable    = s1_data_ff.hop_enable;
      cur.hop_prb_start = s1_data_ff.hop_prb_start;
      cur.mux           = mux_index(s1_data_ff.format, s1_data_ff.cyclic_shift,
                                    s1_data_ff.time_occ, s1_data_ff.cover_index);
   end

   always_comb begin
      ha[0] = hop_rect(kept_ff, 1'b0);
      ha[1] = hop_rect(kept_ff, 1'b1);
      hb[0] = hop_rect(cur, 1'b0);
      hb[1] = hop_rect(cur, 1'b1);
      any_overlap = rect_overlap(ha[0], hb[0])
                 || (kept_ff.hop_enable && rect_overlap(ha[1], hb[0]))
                 || (cur.hop_enable && rect_overlap(ha[0], hb[1]))
                 || (kept_ff.hop_enable && cur.hop_enable && rect_overlap(ha[1], hb[1]));
      hops_same = (kept_ff.hop_enable == cur.hop_enable) && (ha[0] == hb[0])
               && (!cur.hop_enable || (ha[1] == hb[1]));
      if (!any_overlap) begin
         collide_in = 1'b0;
      end else if ((kept_ff.format != cur.format) || !hops_same) begin
         collide_in = 1'b1;
      end else begin
         collide_in = (kept_ff.mux == cur.mux);
      end
   end

   assign s1_advance = s1_valid_ff
                    && ((s1_data_ff.kind == ucrc_pkg::KIND_STORE) || !out_valid_ff
                        || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign s1_valid_in = req_chan.valid || (s1_valid_ff && !s1_advance);

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (s1_advance && (s1_data_ff.kind == ucrc_pkg::KIND_COMPARE)) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         kept_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_advance && (s1_data_ff.kind == ucrc_pkg::KIND_STORE)) begin
            kept_ff <= cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_data_ff <= req_chan.payload;
      end
      if (s1_advance && (s1_data_ff.kind == ucrc_pkg::KIND_COMPARE)) begin
         collide_ff <= collide_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.payload.collide = collide_ff;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned TotalBeats = 1950;

   typedef struct packed {
      int unsigned s0;
      int unsigned s1;
      int unsigned p0;
      int unsigned p1;
   } box_type;

   class collision_board;
      ucrc_pkg::req_type kept_res;
      logic [8:0]        kept_mux;
      bit                collide_q[$];
      int unsigned       failures;

      function new();
         kept_res  = '0;
         kept_mux  = '0;
         failures  = 0;
      endfunction

      function logic [8:0] mux_of(ucrc_pkg::req_type r);
         case (r.format)
            ucrc_pkg::FMT_0: return 9'(r.cyclic_shift);
            ucrc_pkg::FMT_1: return 9'(r.cyclic_shift)
                                    + 9'(r.time_occ) * 9'(ucrc_pkg::ShiftsPerCover);
            ucrc_pkg::FMT_4: return 9'(r.cover_index);
            default:         return 9'd0;
         endcase
      endfunction

      function int split_hops(ucrc_pkg::req_type r, output box_type h0, output box_type h1);
         int unsigned half;
         half  = r.sym_len / ucrc_pkg::HopDivisor;
         h0.p0 = r.prb_start;
         h0.p1 = r.prb_start + r.prb_len;
         h0.s0 = r.sym_start;
         h1    = '0;
         if (r.hop_enable) begin
            h0.s1 = r.sym_start + half;
            h1.s0 = r.sym_start + half;
            h1.s1 = r.sym_start + r.sym_len;
            h1.p0 = r.hop_prb_start;
            h1.p1 = r.hop_prb_start + r.prb_len;
            return 2;
         end
         h0.s1 = r.sym_start + r.sym_len;
         return 1;
      endfunction

      function bit boxes_meet(box_type a, box_type b);
         return a.s0 < b.s1 && b.s0 < a.s1 && a.p0 < b.p1 && b.p0 < a.p1;
      endfunction

      function bit predict_collide(ucrc_pkg::req_type cur);
         box_type a0, a1, b0, b1;
         int      na, nb;
         bit      any;
         na  = split_hops(kept_res, a0, a1);
         nb  = split_hops(cur, b0, b1);
         any = boxes_meet(a0, b0)
               || (nb == 2 && boxes_meet(a0, b1))
               || (na == 2 && boxes_meet(a1, b0))
               || (na == 2 && nb == 2 && boxes_meet(a1, b1));
         if (!any) return 1'b0;
         if (kept_res.format != cur.format) return 1'b1;
         if (na != nb) return 1'b1;
         if (a0 != b0) return 1'b1;
         if (na == 2 && a1 != b1) return 1'b1;
         return kept_mux == mux_of(cur);
      endfunction

      function void note_beat(ucrc_pkg::req_type b);
         if (b.kind == ucrc_pkg::KIND_STORE) begin
            kept_res = b;
            kept_mux = mux_of(b);
         end else begin
            collide_q.push_back(predict_collide(b));
         end
      endfunction

      function void check_result(ucrc_pkg::rsp_type got);
         bit want;
         if (collide_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: collide=%0b arrived with no compare outstanding",
                        got.collide);
            return;
         end
         want = collide_q.pop_front();
         if (got.collide !== want) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: collide expected %0b actual %0b", want, got.collide);
         end
      endfunction

      function int pending();
         return collide_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   ucrc_req_if req_if ();
   ucrc_rsp_if rsp_if ();

   uplink_control_resource_collision u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   collision_board board;
   int unsigned    beats_sent;
   int unsigned    hold_request;
   bit             calm;
   int unsigned    cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   function automatic ucrc_pkg::req_type mk(logic kind, int fmt, int ss, int sl, int ps,
                                            int pl, int hop, int hps, int cs, int tocc,
                                            int occ);
      ucrc_pkg::req_type r;
      r.kind          = kind;
      r.format        = 3'(fmt);
      r.sym_start     = 4'(ss);
      r.sym_len       = 4'(sl);
      r.prb_start     = 9'(ps);
      r.prb_len       = 5'(pl);
      r.hop_enable    = 1'(hop);
      r.hop_prb_start = 9'(hps);
      r.cyclic_shift  = 4'(cs);
      r.time_occ      = 3'(tocc);
      r.cover_index   = 2'(occ);
      return r;
   endfunction

   function automatic ucrc_pkg::req_type well_formed();
      ucrc_pkg::req_type r;
      r.kind          = ucrc_pkg::KIND_STORE;
      r.format        = 3'($urandom_range(0, 4));
      r.sym_start     = 4'($urandom_range(0, 13));
      r.sym_len       = 4'($urandom_range(1, 14 - r.sym_start));
      r.prb_start     = 9'($urandom_range(0, 24));
      if ($urandom_range(0, 3) == 0)
         r.prb_start = 9'($urandom_range(0, ucrc_pkg::NumBlocks - 1));
      r.prb_len       = 5'($urandom_range(1, 16));
      r.hop_enable    = 1'($urandom_range(0, 1));
      r.hop_prb_start = 9'($urandom_range(0, 40));
      if ($urandom_range(0, 3) == 0)
         r.hop_prb_start = 9'($urandom_range(0, ucrc_pkg::NumBlocks - 1));
      r.cyclic_shift  = 4'($urandom_range(0, ucrc_pkg::ShiftsPerCover - 1));
      r.time_occ      = 3'($urandom_range(0, 6));
      r.cover_index   = 2'($urandom_range(0, 3));
      return r;
   endfunction

   function automatic ucrc_pkg::req_type noise_beat();
      logic [63:0]       w;
      ucrc_pkg::req_type r;
      w = {$urandom, $urandom};
      r = w[$bits(ucrc_pkg::req_type)-1:0];
      return r;
   endfunction

   function automatic ucrc_pkg::req_type variant_of(ucrc_pkg::req_type base);
      ucrc_pkg::req_type r;
      r      = base;
      r.kind = ucrc_pkg::KIND_COMPARE;
      case ($urandom_range(0, 7))
         0, 1: begin
            if ($urandom_range(0, 1)) r.cyclic_shift = 4'($urandom_range(0, 2));
            if ($urandom_range(0, 1)) r.time_occ = 3'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) r.cover_index = 2'($urandom_range(0, 1));
         end
         2: r.format = 3'($urandom_range(0, 4));
         3: r.hop_enable = ~r.hop_enable;
         4: begin
            r.sym_start = 4'(int'(r.sym_start) + $urandom_range(0, 2));
            r.prb_start = 9'(int'(r.prb_start) + $urandom_range(0, 3));
         end
         5: r.hop_prb_start = 9'(int'(r.hop_prb_start) + $urandom_range(0, 2));
         6: begin
            r      = well_formed();
            r.kind = ucrc_pkg::KIND_COMPARE;
         end
         default: begin
            r.sym_len = 4'($urandom_range(0, 15));
            r.prb_len = 5'($urandom_range(0, 31));
         end
      endcase
      return r;
   endfunction

   task automatic send_beat(input ucrc_pkg::req_type b);
      int unsigned gap;
      req_if.valid   <= 1'b1;
      req_if.payload <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_beat(b);
      beats_sent++;
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic run_sequences(input int unsigned target);
      ucrc_pkg::req_type base;
      int unsigned       n;
      while (beats_sent < target) begin
         if ($urandom_range(0, 9) < 3) begin
            send_beat(noise_beat());
         end else begin
            base = well_formed();
            send_beat(base);
            n = $urandom_range(1, 4);
            repeat (n) send_beat(variant_of(base));
         end
      end
   endtask

   task automatic run_directed();
      // compare against the reset resource: empty intervals never meet
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 0, 0, 14, 0, 16, 0, 0, 0, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_STORE, 0, 0, 14, 0, 4, 0, 0, 3, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 0, 0, 14, 0, 4, 0, 0, 3, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 0, 0, 14, 0, 4, 0, 0, 4, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 1, 0, 14, 0, 4, 0, 0, 3, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 0, 0, 14, 4, 4, 0, 0, 3, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_STORE, 1, 2, 10, 20, 2, 1, 100, 11, 6, 0));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 1, 2, 10, 20, 2, 1, 100, 11, 6, 3));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 1, 2, 10, 20, 2, 1, 100, 11, 5, 0));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 1, 2, 10, 20, 2, 0, 100, 11, 6, 0));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 1, 7, 5, 99, 2, 0, 0, 15, 7, 0));
      send_beat(mk(ucrc_pkg::KIND_STORE, 4, 13, 1, 274, 16, 0, 274, 0, 0, 3));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 4, 13, 1, 274, 16, 0, 0, 9, 2, 3));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 4, 13, 1, 274, 16, 0, 0, 0, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_STORE, 2, 15, 15, 511, 31, 1, 511, 15, 7, 3));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 2, 15, 15, 511, 31, 1, 511, 0, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 3, 15, 15, 511, 31, 1, 511, 0, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_STORE, 5, 3, 6, 40, 3, 0, 0, 1, 1, 1));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 7, 3, 6, 40, 3, 0, 0, 1, 1, 1));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 5, 3, 6, 40, 3, 0, 0, 8, 4, 2));
      // empty intervals inside a wider resource
      send_beat(mk(ucrc_pkg::KIND_STORE, 3, 5, 0, 10, 0, 0, 0, 0, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 3, 0, 14, 0, 20, 0, 0, 0, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 3, 5, 0, 10, 0, 0, 0, 0, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_STORE, 0, 0, 1, 0, 1, 1, 5, 0, 0, 0));
      send_beat(mk(ucrc_pkg::KIND_COMPARE, 0, 0, 1, 5, 1, 0, 0, 0, 0, 0));
   endtask

   task automatic run_pressure();
      ucrc_pkg::req_type base;
      base = well_formed();
      send_beat(base);
      hold_request = 80;
      calm         = 1'b1;
      repeat (40) send_beat(variant_of(base));
      calm         = 1'b0;
   endtask

   // result side: check accepted beats, then choose ready for the next cycle
   initial begin
      int unsigned stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.payload);
         if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      board          = new();
      beats_sent     = 0;
      hold_request   = 0;
      calm           = 1'b0;
      cycle_count    = 0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_sequences(700);
      run_pressure();
      drain();
      calm = 1'b1;
      run_sequences(1150);
      calm = 1'b0;
      run_sequences(TotalBeats);

      drain();
      repeat (8) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
